FILE: hdl/ctpf_pkg.sv
package ctpf_pkg;

    // Default trie size in nodes, root included
    localparam int NODE_COUNT_DEF = 1024;

    // Address width walked by a query
    localparam int ADDR_BITS = 32;
    localparam int PLEN_W    = 6;

    // Input function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Walk sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_DONE
    } walk_state_t;

endpackage

FILE: hdl/ctpf_node_ram.sv
module ctpf_node_ram #(
    parameter int DEPTH  = ctpf_pkg::NODE_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WIDTH  = 1 + 2 * ADDR_W
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/cidr_prefix_trie_filter_top.sv
// Each trie level visited takes a node read (FETCH), then an evaluate (EVAL); on an add, levels
// below a freshly allocated node skip the read since the new node is known empty.
// The result waits in DONE until the output register is free; the walk visits one level at a
// time, because the node memory has a single read port.
// One item is in flight at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous, active low; after reset an init state clears the root node before any input.
module cidr_prefix_trie_filter_top #(
    parameter int NODE_COUNT = ctpf_pkg::NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_address,
    input  logic [5:0]  s_prefix_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_filtered,
    output logic        m_status
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int NODE_W = 1 + 2 * IDX_W;
    localparam int PLEN_W = ctpf_pkg::PLEN_W;
    localparam int ABITS  = ctpf_pkg::ADDR_BITS;

    ctpf_pkg::walk_state_t state_reg, state_next;

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [PLEN_W-1:0] pos_reg, pos_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [ABITS-1:0]  addr_reg, addr_next;
    logic              func_reg, func_next;
    logic              fresh_reg, fresh_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              filt_reg, filt_next;
    logic              stat_reg, stat_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_filtered_reg, m_filtered_next;
    logic              m_status_reg, m_status_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [NODE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [NODE_W-1:0] mem_rdata;

    logic [NODE_W-1:0] node_val;
    logic              node_end;
    logic [IDX_W-1:0]  node_c0;
    logic [IDX_W-1:0]  node_c1;
    logic              walk_bit;
    logic [IDX_W-1:0]  child_idx;
    logic              child_none;
    logic              is_add;
    logic              add_end;
    logic              mem_full;
    logic              query_last;
    logic              s_fire;
    logic              out_free;
    logic [IDX_W-1:0]  new_idx;

    ctpf_node_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (IDX_W),
        .WIDTH  (NODE_W)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Decode the current node; a freshly allocated node is empty
    assign node_val   = fresh_reg ? '0 : mem_rdata;
    assign node_end   = node_val[NODE_W-1];
    assign node_c1    = node_val[2*IDX_W-1:IDX_W];
    assign node_c0    = node_val[IDX_W-1:0];
    assign walk_bit   = addr_reg[~pos_reg[4:0]];
    assign child_idx  = walk_bit ? node_c1 : node_c0;
    assign child_none = (child_idx == '0);
    assign is_add     = (func_reg == ctpf_pkg::FUNC_ADD);
    assign add_end    = (pos_reg == plen_reg);
    assign mem_full   = (used_reg >= CNT_W'(NODE_COUNT));
    assign query_last = (pos_reg == PLEN_W'(ABITS));
    assign new_idx    = used_reg[IDX_W-1:0];
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready    = (state_reg == ctpf_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign m_status   = m_status_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctpf_pkg::ST_INIT: begin
                state_next = ctpf_pkg::ST_IDLE;
            end
            ctpf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = ctpf_pkg::ST_FETCH;
                end
            end
            ctpf_pkg::ST_FETCH: begin
                state_next = ctpf_pkg::ST_EVAL;
            end
            ctpf_pkg::ST_EVAL: begin
                if (is_add) begin
                    if (add_end || (child_none && mem_full)) begin
                        state_next = ctpf_pkg::ST_DONE;
                    end else if (child_none) begin
                        state_next = ctpf_pkg::ST_EVAL;
                    end else begin
                        state_next = ctpf_pkg::ST_FETCH;
                    end
                end else begin
                    if (node_end || query_last || child_none) begin
                        state_next = ctpf_pkg::ST_DONE;
                    end else begin
                        state_next = ctpf_pkg::ST_FETCH;
                    end
                end
            end
            ctpf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ctpf_pkg::ST_IDLE;
                end
            end
            default: state_next = ctpf_pkg::ST_INIT;
        endcase
    end

    // Datapath, memory control and result register
    always_comb begin
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        plen_next       = plen_reg;
        addr_next       = addr_reg;
        func_next       = func_reg;
        fresh_next      = fresh_reg;
        used_next       = used_reg;
        filt_next       = filt_reg;
        stat_next       = stat_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = node_val;
        mem_re          = 1'b0;
        mem_raddr       = cur_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_filtered_next = m_filtered_reg;
        m_status_next   = m_status_reg;

        unique case (state_reg)
            ctpf_pkg::ST_INIT: begin
                // Clear the root
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '0;
            end
            ctpf_pkg::ST_IDLE: begin
                // Capture the transaction, clamp prefix length, start at the root
                if (s_fire) begin
                    func_next  = s_func;
                    addr_next  = s_address;
                    plen_next  = (s_prefix_len > PLEN_W'(ABITS)) ? PLEN_W'(ABITS)
                                                                 : s_prefix_len;
                    cur_next   = '0;
                    pos_next   = '0;
                    fresh_next = 1'b0;
                    filt_next  = 1'b0;
                    stat_next  = ctpf_pkg::STATUS_OK;
                end
            end
            ctpf_pkg::ST_FETCH: begin
                mem_re = 1'b1;
            end
            ctpf_pkg::ST_EVAL: begin
                if (is_add) begin
                    if (add_end) begin
                        // Mark the rule end, keep children
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, node_c1, node_c0};
                    end else if (child_none && mem_full) begin
                        // Write back the current node unchanged (a fresh node as empty), report full
                        mem_we    = 1'b1;
                        mem_wdata = node_val;
                        stat_next = ctpf_pkg::STATUS_FULL;
                    end else if (child_none) begin
                        // Link a new node; it is written when the walk leaves it
                        mem_we     = 1'b1;
                        mem_wdata  = walk_bit ? {node_end, new_idx, node_c0}
                                              : {node_end, node_c1, new_idx};
                        cur_next   = new_idx;
                        used_next  = used_reg + CNT_W'(1);
                        pos_next   = pos_reg + PLEN_W'(1);
                        fresh_next = 1'b1;
                    end else begin
                        cur_next   = child_idx;
                        pos_next   = pos_reg + PLEN_W'(1);
                        fresh_next = 1'b0;
                    end
                end else begin
                    if (node_end) begin
                        filt_next = 1'b1;
                    end else if (!query_last && !child_none) begin
                        cur_next = child_idx;
                        pos_next = pos_reg + PLEN_W'(1);
                    end
                end
            end
            ctpf_pkg::ST_DONE: begin
                // Load the result once the output register is free
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = filt_reg;
                    m_status_next   = stat_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ctpf_pkg::ST_INIT;
            used_reg    <= CNT_W'(1);
            m_valid_reg <= 1'b0;
            fresh_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            fresh_reg   <= fresh_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        plen_reg       <= plen_next;
        addr_reg       <= addr_next;
        func_reg       <= func_next;
        filt_reg       <= filt_next;
        stat_reg       <= stat_next;
        m_filtered_reg <= m_filtered_next;
        m_status_reg   <= m_status_next;
    end

endmodule
